/* rtl/sha1s_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the streaming SHA-1 hasher.
package sha1s_pkg;

  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned LEN_BYTES   = 8;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [2:0] LAST_IDX   = 3'd4;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Working variables of the compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

endpackage

/* rtl/sha1s_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message bytes in and digest words out.
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha1s_round.sv */
`timescale 1ns / 1ps
// One SHA-1 round: the shared function, constant and adder of the compression.
module sha1s_round (
  input  logic [6:0]       round,
  input  logic [31:0]      w,
  input  sha1s_pkg::work_t cur,
  output sha1s_pkg::work_t nxt
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (round < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = sha1s_pkg::K0;
    end else if (round < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = sha1s_pkg::K1;
    end else if (round < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = sha1s_pkg::K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = sha1s_pkg::K3;
    end
  end

  assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

  always_comb begin
    nxt.a = t;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

/* rtl/sha1_stream_hasher.sv */
`timescale 1ns / 1ps
// Streaming SHA-1 hasher: byte absorb, padding, 80-round compression, digest out.
// Absorb: each byte is shifted into the block buffer; the 64th byte of a block starts
//   the 80 rounds on the shared round unit, then the result is folded into the chain.
// Finish: pad bytes are written up to the block end, each full block is compressed
//   (two blocks when the marker lands at 56..63), then five digest words are emitted.
// Input: bytes wait while padding, compressing (one round per cycle) or emitting.
// Reset: synchronous; chain loads the initial hash values, byte count clears, idle.
module sha1_stream_hasher (
  input  logic clk,
  input  logic rst,
  sha1s_in_if.sink    data_in,
  sha1s_out_if.source digest_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  state_t state;

  // Chaining words H0..H4.
  logic [31:0] chain [sha1s_pkg::DIGEST_WORDS];
  // Block buffer doubles as the schedule shift line: word 0 is the oldest.
  logic [31:0] sched [sha1s_pkg::BLOCK_WORDS];
  sha1s_pkg::work_t work;
  sha1s_pkg::work_t work_next;

  // Byte count modulo 2^61 gives the bit length modulo 2^64.
  logic [60:0] count;
  logic [5:0]  fill;        // next byte position in the block
  logic [63:0] len_bits;    // bit length, shifted out big-endian during padding
  logic [6:0]  round;
  logic [2:0]  emit_idx;

  logic pad_first;    // marker byte still to be written
  logic zero_block;   // marker landed late: this block carries no length
  logic padding;      // finish in progress
  logic last_block;   // block under compression ends the message

  logic [7:0]  pad_byte;
  logic [31:0] sched_new;
  logic        in_fire;
  logic        out_fire;

  assign in_fire  = data_in.valid && data_in.ready;
  assign out_fire = digest_out.valid && digest_out.ready;

  assign data_in.ready          = (state == S_IDLE);
  assign digest_out.valid       = (state == S_EMIT);
  assign digest_out.digest_word = chain[emit_idx];
  assign digest_out.word_index  = emit_idx;
  assign digest_out.last_word   = (emit_idx == sha1s_pkg::LAST_IDX);

  // Pad byte: marker first, then zeros, then the length in the last eight slots.
  always_comb begin
    if (pad_first) begin
      pad_byte = sha1s_pkg::PAD_MARK;
    end else if (!zero_block && (fill >= sha1s_pkg::LEN_POS)) begin
      pad_byte = len_bits[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Message expansion tap: W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t]).
  always_comb begin
    sched_new = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    sched_new = {sched_new[30:0], sched_new[31]};
  end

  sha1s_round u_round (
    .round (round),
    .w     (sched[0]),
    .cur   (work),
    .nxt   (work_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chain[0]   <= sha1s_pkg::IV0;
      chain[1]   <= sha1s_pkg::IV1;
      chain[2]   <= sha1s_pkg::IV2;
      chain[3]   <= sha1s_pkg::IV3;
      chain[4]   <= sha1s_pkg::IV4;
      count      <= '0;
      fill       <= '0;
      round      <= '0;
      emit_idx   <= '0;
      pad_first  <= 1'b0;
      zero_block <= 1'b0;
      padding    <= 1'b0;
      last_block <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (data_in.action == sha1s_pkg::ACT_ABSORB) begin
              // Shift the byte into the block buffer.
              for (int i = 0; i < 15; i++) begin
                sched[i] <= {sched[i][23:0], sched[i+1][31:24]};
              end
              sched[15] <= {sched[15][23:0], data_in.data_byte};
              count     <= count + 61'd1;
              fill      <= fill + 6'd1;
              if (fill == sha1s_pkg::LAST_POS) begin
                work       <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
                round      <= '0;
                last_block <= 1'b0;
                padding    <= 1'b0;
                state      <= S_ROUND;
              end
            end else begin
              len_bits   <= {count, 3'b000};
              pad_first  <= 1'b1;
              zero_block <= 1'b0;
              padding    <= 1'b1;
              state      <= S_PAD;
            end
          end
        end

        S_PAD: begin
          for (int i = 0; i < 15; i++) begin
            sched[i] <= {sched[i][23:0], sched[i+1][31:24]};
          end
          sched[15] <= {sched[15][23:0], pad_byte};
          fill      <= fill + 6'd1;
          if (pad_first) begin
            pad_first <= 1'b0;
            // Marker at 56..62 leaves no room for the length: this block carries none.
            if ((fill >= sha1s_pkg::LEN_POS) && (fill != sha1s_pkg::LAST_POS)) begin
              zero_block <= 1'b1;
            end
          end else if (!zero_block && (fill >= sha1s_pkg::LEN_POS)) begin
            len_bits <= {len_bits[55:0], 8'h00};
          end
          if (fill == sha1s_pkg::LAST_POS) begin
            // Block full: compress it; a late marker leaves no room for length.
            work       <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
            round      <= '0;
            last_block <= !zero_block && !pad_first;
            zero_block <= 1'b0;
            state      <= S_ROUND;
          end
        end

        S_ROUND: begin
          work <= work_next;
          for (int i = 0; i < 15; i++) begin
            sched[i] <= sched[i+1];
          end
          sched[15] <= sched_new;
          if (round == sha1s_pkg::LAST_ROUND) begin
            round <= '0;
            state <= S_FOLD;
          end else begin
            round <= round + 7'd1;
          end
        end

        S_FOLD: begin
          chain[0] <= chain[0] + work.a;
          chain[1] <= chain[1] + work.b;
          chain[2] <= chain[2] + work.c;
          chain[3] <= chain[3] + work.d;
          chain[4] <= chain[4] + work.e;
          if (last_block) begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (out_fire) begin
            if (emit_idx == sha1s_pkg::LAST_IDX) begin
              // Digest delivered: re-initialize for the next message.
              chain[0]   <= sha1s_pkg::IV0;
              chain[1]   <= sha1s_pkg::IV1;
              chain[2]   <= sha1s_pkg::IV2;
              chain[3]   <= sha1s_pkg::IV3;
              chain[4]   <= sha1s_pkg::IV4;
              count      <= '0;
              fill       <= '0;
              emit_idx   <= '0;
              padding    <= 1'b0;
              last_block <= 1'b0;
              state      <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 3'd1;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
